[rtl/kwm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, field widths and codes for the k-way sorted merge block.
// Depends on nothing; every other file of the block imports it.
package kwm_pkg;

	// Field widths of the input and result transactions.
	localparam int DATA_W = 32;
	localparam int WAY_FW = 2;
	localparam int STAT_W = 2;

	// Default configuration of the top level.
	localparam int WAYS_DEF      = 4;
	localparam int WAY_DEPTH_DEF = 16;

	// Depth of the command queue between front and back; a power of two.
	localparam int CMDQ_DEPTH = 2;

	// Function codes of an input transaction.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	// Status codes of a result transaction.
	localparam logic [STAT_W-1:0] STAT_LOADED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MERGED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	typedef struct packed {
		logic                     func;
		logic [WAY_FW-1:0]        way;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] merged;
		logic [WAY_FW-1:0]        from_way;
	} out_item_t;

	// A classified command as the front hands it to the back.
	typedef struct packed {
		logic                     is_pull;
		logic                     way_ok;
		logic [WAY_FW-1:0]        way;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

[rtl/k_way_sorted_merge.sv]
`timescale 1ns / 1ps
// Top level of the k-way sorted merge: front stage, command queue and back end.
// Depends on kwm_pkg, kwm_front, kwm_cmd_queue and kwm_back.
//
// Channel   Handshake          Payload
// input     push / full        item   (func, way, value)
// result    empty / pop        result (status, merged, from_way)
//
// A load is served in the back end's ready state; a pull reads the head of every way
// buffer, then the comparison tree takes the heads once the result register is free.
// Transactions enter the front stage every cycle until it and the queue are full.
// Reset clears all pointers and fill counts at once; no clearing pass is needed.
// While a result waits in the output register, pulls still read their heads and
// loads wait; the front keeps accepting into the queue.
module k_way_sorted_merge #(
	parameter int WAYS      = kwm_pkg::WAYS_DEF,
	parameter int WAY_DEPTH = kwm_pkg::WAY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  kwm_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output kwm_pkg::out_item_t result
);
	import kwm_pkg::*;

	logic cmdq_push;
	logic cmdq_full;
	logic cmdq_pop;
	logic cmdq_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	// Front: accept and classify transactions.
	kwm_front #(
		.WAYS(WAYS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_push(cmdq_push),
		.cmd_full(cmdq_full),
		.cmd     (cmd_in)
	);

	// Queue that decouples the front from the back.
	kwm_cmd_queue u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmdq_push),
		.full  (cmdq_full),
		.din   (cmd_in),
		.pop   (cmdq_pop),
		.empty (cmdq_empty),
		.dout  (cmd_out)
	);

	// Back: buffers, merge and result register.
	kwm_back #(
		.WAYS     (WAYS),
		.WAY_DEPTH(WAY_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmdq_empty),
		.cmd_pop  (cmdq_pop),
		.cmd      (cmd_out),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	// The front never offers a command to a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmdq_push |-> !cmdq_full)
		else $error("command pushed into a full queue");

	// The back never takes a command from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmdq_pop |-> !cmdq_empty)
		else $error("command popped from an empty queue");

	// Only a merged result carries a value and a way.
	a_zero_unless_merged: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != STAT_MERGED) |-> (result.merged == '0 &&
		result.from_way == '0))
		else $error("non-merged result carries data");
`endif

endmodule

[rtl/kwm_front.sv]
`timescale 1ns / 1ps
// Front stage: accepts input transactions and classifies them into commands.
// Depends on kwm_pkg.
module kwm_front #(
	parameter int WAYS = kwm_pkg::WAYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  kwm_pkg::in_item_t item,
	output logic              cmd_push,
	input  logic              cmd_full,
	output kwm_pkg::cmd_t     cmd
);
	import kwm_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	logic accept;

	// The stage holds one command; it frees when the queue takes it unless refilled.
	assign cmd_push = vld_s1 && !cmd_full;
	assign full     = vld_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (cmd_push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Decode the function and check that the named way exists.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_pull <= (item.func == FUNC_PULL);
			cmd_s1.way_ok  <= (32'(item.way) < 32'(WAYS));
			cmd_s1.way     <= item.way;
			cmd_s1.value   <= item.value;
		end
	end

endmodule

[rtl/kwm_cmd_queue.sv]
`timescale 1ns / 1ps
// Short first-in first-out queue of commands between the front and the back.
// Depends on kwm_pkg.
module kwm_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  kwm_pkg::cmd_t din,
	input  logic          pop,
	output logic          empty,
	output kwm_pkg::cmd_t dout
);
	import kwm_pkg::*;

	localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          slots_q [CMDQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slots_q[rd_ptr_q];

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/kwm_back.sv]
`timescale 1ns / 1ps
// Back end: per-way buffers, the head comparison tree and the result register.
// Depends on kwm_pkg.
module kwm_back #(
	parameter int WAYS      = kwm_pkg::WAYS_DEF,
	parameter int WAY_DEPTH = kwm_pkg::WAY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	input  kwm_pkg::cmd_t      cmd,
	output logic               empty,
	input  logic               pop,
	output kwm_pkg::out_item_t result
);
	import kwm_pkg::*;

	localparam int WIDX_W = $clog2(WAYS);
	localparam int ADDR_W = (WAY_DEPTH > 1) ? $clog2(WAY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WAY_DEPTH + 1);
	localparam int NP     = 1 << WIDX_W;
	localparam int NODES  = 2 * NP - 1;

	localparam logic ST_READY = 1'b0;
	localparam logic ST_CMP   = 1'b1;

	logic                     state_q;
	logic [ADDR_W-1:0]        rd_addr_q [WAYS];
	logic [ADDR_W-1:0]        wr_addr_q [WAYS];
	logic [CNT_W-1:0]         cnt_q     [WAYS];
	logic signed [DATA_W-1:0] head_s2   [WAYS];
	logic                     out_vld_q;
	out_item_t                out_q;

	logic                     node_vld [NODES];
	logic signed [DATA_W-1:0] node_val [NODES];
	logic [WIDX_W-1:0]        node_way [NODES];

	logic              out_free;
	logic              is_load;
	logic              load_ok;
	logic              wr_en;
	logic              rd_en;
	logic              cmp_done;
	logic              adv;
	logic [WIDX_W-1:0] load_idx;

	// Command issue: a load needs the result register, a pull only reads heads.
	assign out_free = !out_vld_q || pop;
	assign cmd_pop  = (state_q == ST_READY) && !cmd_empty && (cmd.is_pull || out_free);
	assign is_load  = cmd_pop && !cmd.is_pull;
	assign rd_en    = cmd_pop && cmd.is_pull;
	assign load_idx = WIDX_W'(cmd.way);
	assign load_ok  = cmd.way_ok && (cnt_q[load_idx] != CNT_W'(WAY_DEPTH));
	assign wr_en    = is_load && load_ok;
	assign cmp_done = (state_q == ST_CMP) && out_free;
	assign adv      = cmp_done && node_vld[0];

	assign empty  = !out_vld_q;
	assign result = out_q;

	// One buffer per way, written at its tail and read at its head.
	for (genvar g = 0; g < WAYS; g++) begin : g_way
		logic signed [DATA_W-1:0] mem_q [WAY_DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && load_idx == WIDX_W'(g)) begin
				mem_q[wr_addr_q[g]] <= cmd.value;
			end
			if (rd_en) begin
				head_s2[g] <= mem_q[rd_addr_q[g]];
			end
		end
	end

	// Leaves of the comparison tree; padding leaves never win.
	for (genvar i = 0; i < NP; i++) begin : g_leaf
		if (i < WAYS) begin : g_real
			assign node_vld[NP-1+i] = (cnt_q[i] != '0);
			assign node_val[NP-1+i] = head_s2[i];
			assign node_way[NP-1+i] = WIDX_W'(i);
		end else begin : g_pad
			assign node_vld[NP-1+i] = 1'b0;
			assign node_val[NP-1+i] = '0;
			assign node_way[NP-1+i] = '0;
		end
	end

	// Inner nodes keep the lesser head; the left side holds the lower ways and wins ties.
	for (genvar n = 0; n < NP - 1; n++) begin : g_node
		logic take_left;

		assign take_left = node_vld[2*n+1] &&
			(!node_vld[2*n+2] || node_val[2*n+1] <= node_val[2*n+2]);
		assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
		assign node_val[n] = take_left ? node_val[2*n+1] : node_val[2*n+2];
		assign node_way[n] = take_left ? node_way[2*n+1] : node_way[2*n+2];
	end

	// Sequencer: a pull reads heads in ST_READY, then ST_CMP compares them once out_free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
		end else begin
			case (state_q)
				ST_READY: begin
					if (rd_en) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmp_done) begin
						state_q <= ST_READY;
					end
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

	// Per-way tail, head and fill count; loads and pulls never complete together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WAYS; w++) begin
				rd_addr_q[w] <= '0;
				wr_addr_q[w] <= '0;
				cnt_q[w]     <= '0;
			end
		end else begin
			for (int w = 0; w < WAYS; w++) begin
				if (wr_en && load_idx == WIDX_W'(w)) begin
					wr_addr_q[w] <= (wr_addr_q[w] == ADDR_W'(WAY_DEPTH - 1)) ?
						'0 : wr_addr_q[w] + 1'b1;
					cnt_q[w]     <= cnt_q[w] + 1'b1;
				end else if (adv && node_way[0] == WIDX_W'(w)) begin
					rd_addr_q[w] <= (rd_addr_q[w] == ADDR_W'(WAY_DEPTH - 1)) ?
						'0 : rd_addr_q[w] + 1'b1;
					cnt_q[w]     <= cnt_q[w] - 1'b1;
				end
			end
		end
	end

	// Result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (is_load || cmp_done) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (is_load) begin
			out_q.status   <= load_ok ? STAT_LOADED : STAT_FULL;
			out_q.merged   <= '0;
			out_q.from_way <= '0;
		end else if (cmp_done) begin
			if (node_vld[0]) begin
				out_q.status   <= STAT_MERGED;
				out_q.merged   <= node_val[0];
				out_q.from_way <= WAY_FW'(node_way[0]);
			end else begin
				out_q.status   <= STAT_EMPTY;
				out_q.merged   <= '0;
				out_q.from_way <= '0;
			end
		end
	end

endmodule

[tb/tb_k_way_sorted_merge.sv]
`timescale 1ns / 1ps
// Self-checking testbench for k_way_sorted_merge: directed extremes, random merge rounds and noise.
// Depends on kwm_pkg and the k_way_sorted_merge RTL; a built-in predictor checks every result.
module tb_k_way_sorted_merge;
	import kwm_pkg::*;

	localparam int NWAYS       = WAYS_DEF;
	localparam int DEPTH       = WAY_DEPTH_DEF;
	localparam int TARGET      = 1050;
	localparam int CALM_FROM   = 880;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	logic      full;
	logic      empty;
	in_item_t  item   = '0;
	out_item_t result;

	k_way_sorted_merge dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always #1 clk = ~clk;

	// Predictor state: one circular buffer per way, pointers one bit wider than the index.
	logic signed [DATA_W-1:0] way_buf [NWAYS][DEPTH];
	logic [4:0]               head_ptr [NWAYS];
	logic [4:0]               tail_ptr [NWAYS];

	out_item_t pending_results [$];
	int        items_sent = 0;
	int        errors     = 0;
	int        cycles     = 0;
	bit        calm       = 1'b0;
	int        pop_stall  = 0;
	int        n_loaded = 0, n_dropped = 0, n_merged = 0, n_drained = 0;

	// Merge prediction: a load appends unless the way is full; a pull takes the least head.
	function automatic out_item_t merge_predict(input in_item_t it);
		out_item_t r;
		logic [4:0] fill;
		bit found;
		int w;
		r = '0;
		found = 1'b0;
		if (it.func == FUNC_LOAD) begin
			fill = tail_ptr[it.way] - head_ptr[it.way];
			if (int'(it.way) >= NWAYS || fill >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				way_buf[it.way][tail_ptr[it.way][3:0]] = it.value;
				tail_ptr[it.way] = tail_ptr[it.way] + 5'd1;
				r.status = STAT_LOADED;
			end
			return r;
		end
		for (w = 0; w < NWAYS; w++) begin
			if (tail_ptr[w] != head_ptr[w]) begin
				if (!found || way_buf[w][head_ptr[w][3:0]] < r.merged) begin
					found = 1'b1;
					r.merged = way_buf[w][head_ptr[w][3:0]];
					r.from_way = WAY_FW'(w);
				end
			end
		end
		if (found) begin
			r.status = STAT_MERGED;
			head_ptr[r.from_way] = head_ptr[r.from_way] + 5'd1;
		end else begin
			r.status = STAT_EMPTY;
		end
		return r;
	endfunction

	// Send one input transaction, with an occasional idle burst before it unless calm.
	task automatic send_item(input in_item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		pending_results.insert(pending_results.size(), merge_predict(it));
		items_sent++;
	endtask

	task automatic send_load(input int w, input logic signed [DATA_W-1:0] v);
		in_item_t it;
		it.func = FUNC_LOAD;
		it.way = WAY_FW'(w);
		it.value = v;
		send_item(it);
	endtask

	// Pulls carry random way and value bits, which the block must ignore.
	task automatic send_pull();
		in_item_t it;
		it.func = FUNC_PULL;
		it.way = WAY_FW'($urandom);
		it.value = $urandom;
		send_item(it);
	endtask

	// Hold the input side until every outstanding result has been taken.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// One well-formed round: non-decreasing sequences into each way, then pulls past the end.
	task automatic merge_round();
		int remaining [NWAYS];
		logic signed [DATA_W-1:0] last [NWAYS];
		bit started [NWAYS];
		int loads, extra, w, step, spread;
		longint nxt;
		loads = 0;
		spread = $urandom_range(0, 2);
		for (w = 0; w < NWAYS; w++) begin
			remaining[w] = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 18)
			                                            : $urandom_range(0, 8);
			started[w] = 1'b0;
			loads += remaining[w];
		end
		while (loads > 0) begin
			// Pulls interleaved with loads keep the merge honest mid-stream.
			if ($urandom_range(0, 5) == 0) begin
				send_pull();
				continue;
			end
			w = $urandom_range(0, NWAYS - 1);
			while (remaining[w] == 0) w = (w + 1) % NWAYS;
			if (!started[w]) begin
				last[w] = (spread == 0) ? DATA_W'($urandom_range(0, 6)) - 3 : $urandom;
				started[w] = 1'b1;
			end else begin
				step = (spread == 0) ? $urandom_range(0, 1) :
				       (spread == 1) ? $urandom_range(0, 1000) : $urandom_range(0, 1 << 24);
				nxt = longint'(last[w]) + step;
				last[w] = (nxt > longint'(MAX_VAL)) ? MAX_VAL : DATA_W'(nxt);
			end
			send_load(w, last[w]);
			remaining[w]--;
			loads--;
		end
		extra = 0;
		for (w = 0; w < NWAYS; w++) extra += int'(tail_ptr[w] - head_ptr[w]);
		repeat (extra + $urandom_range(0, 2)) send_pull();
	endtask

	// A burst of fully random transactions.
	task automatic noise_burst();
		in_item_t it;
		repeat ($urandom_range(10, 30)) begin
			it.func = 1'($urandom);
			it.way = WAY_FW'($urandom);
			it.value = $urandom;
			send_item(it);
		end
	endtask

	// Extremes, ties and the empty pull.
	task automatic test_directed();
		send_pull();
		send_load(0, MIN_VAL);
		send_load(1, MAX_VAL);
		send_load(2, -1);
		send_load(3, -1);
		send_load(0, 5);
		send_load(2, MAX_VAL);
		repeat (7) send_pull();
		wait_drained();
	endtask

	// Fill one way past its depth, wait for the results, then drain it with pulls.
	task automatic test_way_full();
		int i;
		for (i = 0; i < DEPTH + 1; i++) send_load(3, MIN_VAL + i);
		wait_drained();
		repeat (DEPTH + 1) send_pull();
		wait_drained();
	endtask

	task automatic test_random_mix();
		while (items_sent < CALM_FROM) begin
			if ($urandom_range(0, 9) < 8) merge_round();
			else noise_burst();
			if ($urandom_range(0, 9) == 0) wait_drained();
		end
	endtask

	task automatic test_calm_tail();
		calm = 1'b1;
		while (items_sent < TARGET) merge_round();
	endtask

	// Result side: random pop stalls and the field-by-field check.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %p", $time, result);
					errors++;
				end else begin
					automatic out_item_t want = pending_results.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status: expected %0d, actual %0d",
						         $time, want.status, result.status);
						errors++;
					end
					if (result.merged !== want.merged) begin
						$display("%0t: merged: expected %0d, actual %0d",
						         $time, want.merged, result.merged);
						errors++;
					end
					if (result.from_way !== want.from_way) begin
						$display("%0t: from_way: expected %0d, actual %0d",
						         $time, want.from_way, result.from_way);
						errors++;
					end
					case (want.status)
						STAT_LOADED: n_loaded++;
						STAT_FULL:   n_dropped++;
						STAT_MERGED: n_merged++;
						default:     n_drained++;
					endcase
				end
			end
			if (pop_stall > 0) begin
				pop_stall--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				pop_stall = $urandom_range(0, 2);
			end
			pop <= (pop_stall == 0) && (calm || $urandom_range(0, 4) != 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_k_way_sorted_merge: FAIL");
			$finish;
		end
	end

	initial begin
		int w;
		for (w = 0; w < NWAYS; w++) begin
			head_ptr[w] = '0;
			tail_ptr[w] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_way_full();
		test_random_mix();
		test_calm_tail();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d transactions; results: %0d loaded, %0d dropped on a full way,",
		         items_sent, n_loaded, n_dropped);
		$display("%0d merged values and %0d pulls with every way empty.", n_merged, n_drained);
		if (errors == 0) begin
			$display("tb_k_way_sorted_merge: PASS");
		end else begin
			$display("tb_k_way_sorted_merge: FAIL");
		end
		$finish;
	end

endmodule
